FILE: src/iom_pkg.sv
// Shared constants, codes and types for the interval overlap matcher.
`timescale 1ns / 1ps
package iom_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TIME_W      = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OVL_W       = TIME_W + 1;
  localparam int ADDR_W      = 3;
  localparam int RIDX_W      = ADDR_W - 2;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // pick strategies; bit 1 set means largest overlap
  localparam logic [1:0] PICK_FIRST   = 2'd0;
  localparam logic [1:0] PICK_LAST    = 2'd1;
  localparam logic [1:0] PICK_LARGEST = 2'd2;

  // register index
  localparam logic [RIDX_W-1:0] REG_PICK = RIDX_W'(0);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_t;

  // write into one cell of the table
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] s_time;
    logic [TIME_W-1:0] e_time;
  } load_t;

  // query token passed down the row of cells
  typedef struct packed {
    logic [TIME_W-1:0] s_time;
    logic [TIME_W-1:0] e_time;
    logic [CNT_W-1:0]  cnt;
    logic [IDX_W-1:0]  idx;
    logic [OVL_W-1:0]  ovl;
  } tok_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
    logic [OVL_W-1:0]  ovl;
    logic [OVL_W-1:0]  tlen;
  } res_t;

endpackage

FILE: src/iom_cell.sv
// One table entry: holds a reference interval and updates the passing query token.
`timescale 1ns / 1ps
module iom_cell import iom_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [CNT_W-1:0]  entry_count,
  input  logic [1:0]        pick,
  input  load_t             wr,
  input  logic              tok_vld_in,
  input  tok_t              tok_in,
  output logic              tok_vld_out,
  output tok_t              tok_out
);

  logic [TIME_W-1:0] ref_s_r;
  logic [TIME_W-1:0] ref_e_r;
  logic              tok_vld_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              active;
  logic [TIME_W-1:0] lo;
  logic [TIME_W-1:0] hi;
  logic              hit;
  logic              take;
  logic [OVL_W-1:0]  ov;

  always_ff @(posedge clk) begin
    if (wr.we && (wr.idx == cell_idx)) begin
      ref_s_r <= wr.s_time;
      ref_e_r <= wr.e_time;
    end
  end

  always_comb begin
    active = ({1'b0, cell_idx} < entry_count);
    lo     = (tok_in.s_time >= ref_s_r) ? tok_in.s_time : ref_s_r;
    hi     = (tok_in.e_time <= ref_e_r) ? tok_in.e_time : ref_e_r;
    // reversed target or entry lands here with lo above hi
    hit    = tok_vld_in && active && (lo <= hi);
    ov     = {1'b0, hi} - {1'b0, lo} + OVL_W'(1);
    take   = hit && ((tok_in.cnt == '0) || (pick == PICK_LAST) ||
                     (pick[1] && (ov > tok_in.ovl)));
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.idx = cell_idx;
      tok_nxt.ovl = ov;
    end
    if (hit) begin
      tok_nxt.cnt = tok_in.cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

FILE: src/interval_overlap_match_top.sv
// Top level: control, configuration register, row of table cells and result register.
//
//   channel   ports                               direction
//   in        in_valid/in_ready, in_op, times     beat in
//   out       out_valid/out_ready, result fields  beat out
//   cfg       psel/penable/pwrite/paddr/pwdata    register write/read
//
// A query token steps through one cell per cycle across all TABLE_DEPTH cells.
// The result is staged once the token leaves the last cell, then moved to the output
// register; the next item is taken once the state machine is back in S_IDLE.
// Load and clear skip the walk: their result is staged at accept and moved out from S_RESP.
// One item is in flight.
// rst_n is synchronous; the table contents are not cleared, only the fill count.
// A stalled result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module interval_overlap_match_top import iom_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [TIME_W-1:0]    in_start_time,
  input  logic [TIME_W-1:0]    in_end_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic                 out_found,
  output logic [IDX_W-1:0]     out_match_index,
  output logic [CNT_W-1:0]     out_match_count,
  output logic [OVL_W-1:0]     out_match_overlap,
  output logic [OVL_W-1:0]     out_target_length,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  state_t            state_r;
  state_t            state_nxt;
  logic [1:0]        pick_r;
  logic [CNT_W-1:0]  cnt_r;
  res_t              res_r;
  res_t              out_res_r;
  logic              out_vld_r;
  logic              in_acc;
  logic              full;
  logic              res_move;
  logic              tail_vld;
  tok_t              tail_tok;
  load_t             wr;
  logic              tok_vld [0:TABLE_DEPTH];
  tok_t              tok     [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tok_vld_vec;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_r <= PICK_FIRST;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_PICK)) begin
      pick_r <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_PICK) begin
      prdata = {30'b0, pick_r};
    end
  end

  // input side
  assign in_acc = in_valid && in_ready;
  assign full   = (cnt_r == CNT_W'(TABLE_DEPTH));

  always_comb begin
    wr.we     = in_acc && (in_op == OP_LOAD) && !full;
    wr.idx    = cnt_r[IDX_W-1:0];
    wr.s_time = in_start_time;
    wr.e_time = in_end_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && (in_op == OP_CLEAR)) begin
      cnt_r <= '0;
    end else if (wr.we) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // inject query token at the head of the row
  assign tok_vld[0] = in_acc && (in_op == OP_QUERY);
  assign tok[0]     = {in_start_time, in_end_time, CNT_W'(0), IDX_W'(0), OVL_W'(0)};

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    iom_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(g)),
      .entry_count (cnt_r),
      .pick        (pick_r),
      .wr          (wr),
      .tok_vld_in  (tok_vld[g]),
      .tok_in      (tok[g]),
      .tok_vld_out (tok_vld[g+1]),
      .tok_out     (tok[g+1])
    );
    assign tok_vld_vec[g] = tok_vld[g+1];
  end

  assign tail_vld = tok_vld[TABLE_DEPTH];
  assign tail_tok = tok[TABLE_DEPTH];

  // state machine: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_op == OP_QUERY)) begin
          state_nxt = S_WALK;
        end else if (in_acc && ((in_op == OP_LOAD) || (in_op == OP_CLEAR))) begin
          state_nxt = S_RESP;
        end
      end
      S_WALK: begin
        if (tail_vld) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_vld_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_ready = 1'b0;
    res_move = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_WALK:  in_ready = 1'b0;
      S_RESP:  res_move = !out_vld_r || out_ready;
      default: begin
        in_ready = 1'b0;
        res_move = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // stage the result of the current item
  always_ff @(posedge clk) begin
    if (state_r == S_WALK && tail_vld) begin
      res_r.status <= (tail_tok.cnt == '0) ? ST_NOMATCH : ST_OK;
      res_r.found  <= (tail_tok.cnt != '0);
      res_r.idx    <= tail_tok.idx;
      res_r.cnt    <= tail_tok.cnt;
      res_r.ovl    <= tail_tok.ovl;
      res_r.tlen   <= (tail_tok.e_time >= tail_tok.s_time) ?
                      ({1'b0, tail_tok.e_time} - {1'b0, tail_tok.s_time} + OVL_W'(1)) :
                      '0;
    end else if (in_acc) begin
      res_r.status <= (in_op == OP_CLEAR) ? ST_CLEARED : (full ? ST_FULL : ST_OK);
      res_r.found  <= 1'b0;
      res_r.idx    <= '0;
      res_r.cnt    <= '0;
      res_r.ovl    <= '0;
      res_r.tlen   <= '0;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_move) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      out_res_r <= res_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = out_res_r.status;
  assign out_found         = out_res_r.found;
  assign out_match_index   = out_res_r.idx;
  assign out_match_count   = out_res_r.cnt;
  assign out_match_overlap = out_res_r.ovl;
  assign out_target_length = out_res_r.tlen;

  // checks
  a_tail_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld |-> (state_r == S_WALK))
    else $error("query token left the row outside a walk");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld_vec))
    else $error("more than one query token in the row");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_query_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_QUERY)) |=> (state_r == S_WALK))
    else $error("accepted query did not start a walk");

endmodule

FILE: tb/iom_checker.sv
// Checker for the interval overlap matcher: mirrors the table, predicts results, compares beats.
`timescale 1ns / 1ps
module iom_checker import iom_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [TIME_W-1:0] in_start_time,
  input  logic [TIME_W-1:0] in_end_time,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_status,
  input  logic              out_found,
  input  logic [IDX_W-1:0]  out_match_index,
  input  logic [CNT_W-1:0]  out_match_count,
  input  logic [OVL_W-1:0]  out_match_overlap,
  input  logic [OVL_W-1:0]  out_target_length,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                mismatches,
  output int                awaiting
);

  logic [TIME_W-1:0] span_lo [TABLE_DEPTH];
  logic [TIME_W-1:0] span_hi [TABLE_DEPTH];
  logic [CNT_W-1:0]  fill;
  logic [1:0]        pick;
  res_t              owed_results [$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  // inclusive overlap of two intervals, zero when disjoint or either is reversed
  function automatic logic [OVL_W-1:0] shared_len(input logic [TIME_W-1:0] s0, e0, s1, e1);
    logic [TIME_W-1:0] lo, hi;
    lo = (s0 > s1) ? s0 : s1;
    hi = (e0 < e1) ? e0 : e1;
    if (lo > hi) return '0;
    return {1'b0, hi} - {1'b0, lo} + OVL_W'(1);
  endfunction

  function automatic res_t match_target(input logic [TIME_W-1:0] s, e);
    res_t             r;
    logic [OVL_W-1:0] ov;
    r = '0;
    if (e >= s) r.tlen = {1'b0, e} - {1'b0, s} + OVL_W'(1);
    for (int i = 0; i < int'(fill); i++) begin
      ov = shared_len(s, e, span_lo[i], span_hi[i]);
      if (ov != '0) begin
        // earliest entry keeps a tie under largest overlap
        if (r.cnt == '0 || pick == PICK_LAST || (pick >= PICK_LARGEST && ov > r.ovl)) begin
          r.idx = IDX_W'(i);
          r.ovl = ov;
        end
        r.cnt = r.cnt + CNT_W'(1);
      end
    end
    r.found  = (r.cnt != '0);
    r.status = r.found ? ST_OK : ST_NOMATCH;
    return r;
  endfunction

  // queue one expected result at the tail
  task automatic owe(input res_t r);
    owed_results.insert(owed_results.size(), r);
  endtask

  task automatic log_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      fill = '0;
      pick = PICK_FIRST;
      owed_results.delete();
      awaiting <= 0;
    end else begin
      got.status = out_status;
      got.found  = out_found;
      got.idx    = out_match_index;
      got.cnt    = out_match_count;
      got.ovl    = out_match_overlap;
      got.tlen   = out_target_length;
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          log_error($sformatf({"result beat with none expected: st=%0d found=%0d",
                               " idx=%0d cnt=%0d ovl=%h tlen=%h"},
                              got.status, got.found, got.idx, got.cnt, got.ovl, got.tlen));
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.idx !== want.idx || got.cnt !== want.cnt ||
              got.ovl !== want.ovl || got.tlen !== want.tlen) begin
            log_error($sformatf({"result mismatch: exp st=%0d found=%0d idx=%0d cnt=%0d",
                                 " ovl=%h tlen=%h | got st=%0d found=%0d idx=%0d cnt=%0d",
                                 " ovl=%h tlen=%h"},
                                want.status, want.found, want.idx, want.cnt, want.ovl,
                                want.tlen, got.status, got.found, got.idx, got.cnt,
                                got.ovl, got.tlen));
          end
        end
      end

      if (in_valid && in_ready) begin
        want = '0;
        case (in_op)
          OP_LOAD: begin
            if (fill >= CNT_W'(TABLE_DEPTH)) begin
              want.status = ST_FULL;
            end else begin
              span_lo[fill[IDX_W-1:0]] = in_start_time;
              span_hi[fill[IDX_W-1:0]] = in_end_time;
              fill = fill + CNT_W'(1);
              want.status = ST_OK;
            end
            owe(want);
          end
          OP_CLEAR: begin
            fill = '0;
            want.status = ST_CLEARED;
            owe(want);
          end
          OP_QUERY: owe(match_target(in_start_time, in_end_time));
          default: ;  // drop: no result, no state change
        endcase
      end

      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_PICK) begin
        if (pwrite) begin
          pick = pwdata[1:0];
        end else if (prdata !== {30'b0, pick}) begin
          log_error($sformatf("register read mismatch: exp %h got %h", {30'b0, pick}, prdata));
        end
      end

      awaiting <= owed_results.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the interval overlap matcher.
`timescale 1ns / 1ps
module testbench;
  import iom_pkg::*;

  localparam logic [1:0] OP_IGNORED         = 2'd3;
  localparam logic [1:0] PICK_LARGEST_ALIAS = 2'd3;
  localparam logic [1:0] PICK_ORDER [4]     = '{PICK_FIRST, PICK_LAST, PICK_LARGEST,
                                                PICK_LARGEST_ALIAS};
  localparam logic [1:0] OP_CODES [4]       = '{OP_LOAD, OP_CLEAR, OP_QUERY, OP_IGNORED};
  localparam int TARGET_BEATS = 850;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam logic [TIME_W-1:0] T_MAX = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op = OP_LOAD;
  logic [TIME_W-1:0] in_start_time = '0;
  logic [TIME_W-1:0] in_end_time = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic              out_found;
  logic [IDX_W-1:0]  out_match_index;
  logic [CNT_W-1:0]  out_match_count;
  logic [OVL_W-1:0]  out_match_overlap;
  logic [OVL_W-1:0]  out_target_length;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int awaiting;
  int beats_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  interval_overlap_match_top uut (.*);

  iom_checker chk (.*);

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 13);
  endfunction

  // intervals clustered around a base so overlaps and ties are common
  function automatic void draw_span(input logic [TIME_W-1:0] base,
                                    output logic [TIME_W-1:0] s, output logic [TIME_W-1:0] e);
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      s = base + TIME_W'($urandom_range(63));
      e = s + TIME_W'($urandom_range(40));
    end else if (r < 70) begin
      e = base + TIME_W'($urandom_range(63));
      s = e + TIME_W'($urandom_range(20, 1));
    end else if (r < 80) begin
      s = base + TIME_W'($urandom_range(63));
      e = s;
    end else if (r < 92) begin
      s = $urandom;
      e = $urandom;
    end else begin
      s = $urandom_range(1) ? '0 : base;
      e = $urandom_range(1) ? T_MAX : base + TIME_W'(100);
    end
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm_rx && $urandom_range(99) < 25) stall_left <= draw_gap();
    end
    if ($urandom_range(2999) == 0) calm_rx <= ~calm_rx;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [TIME_W-1:0] t0, t1);
    int gap;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_start_time <= t0;
    in_end_time   <= t1;
    do @(posedge clk); while (!in_ready);
    if (op != OP_IGNORED) beats_sent++;
    gap = calm_tx ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every result is back, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_PICK, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // now and then a random beat between the regular ones: ignored op, any op, or a stray load
  task automatic maybe_noise(input logic [TIME_W-1:0] base);
    logic [TIME_W-1:0] s, e;
    int r;
    r = $urandom_range(99);
    draw_span(base, s, e);
    if (r < 3) send_beat(OP_IGNORED, $urandom, $urandom);
    else if (r < 5) send_beat(OP_CODES[$urandom_range(3)], s, e);
    else if (r < 7) send_beat(OP_LOAD, s, e);
  endtask

  initial begin
    logic [TIME_W-1:0] base, s, e;
    logic [1:0]        pick_sel;
    int                ph, r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, '0);

    // directed: empty table, extremes, reversed intervals, ignored op, clear
    send_beat(OP_QUERY, 32'd5, 32'd10);
    send_beat(OP_QUERY, T_MAX, '0);
    send_beat(OP_IGNORED, $urandom, $urandom);
    send_beat(OP_LOAD, '0, '0);
    send_beat(OP_LOAD, T_MAX, T_MAX);
    send_beat(OP_LOAD, '0, T_MAX);
    send_beat(OP_LOAD, 32'd100, 32'd50);
    send_beat(OP_LOAD, 32'd10, 32'd20);
    send_beat(OP_LOAD, 32'd15, 32'd30);
    send_beat(OP_QUERY, '0, T_MAX);
    send_beat(OP_QUERY, 32'd15, 32'd20);
    send_beat(OP_QUERY, 32'd100, 32'd50);
    send_beat(OP_QUERY, T_MAX, T_MAX);
    send_beat(OP_QUERY, 32'd40, 32'd60);
    send_beat(OP_IGNORED, '0, T_MAX);
    send_beat(OP_CLEAR, $urandom, $urandom);
    send_beat(OP_QUERY, '0, T_MAX);
    send_beat(OP_LOAD, 32'd5, 32'd5);
    send_beat(OP_QUERY, 32'd5, 32'd5);
    send_beat(OP_CLEAR, '0, '0);

    ph = 0;
    while (beats_sent < TARGET_BEATS) begin
      settle();
      pick_sel = (ph < 4) ? PICK_ORDER[ph] : PICK_ORDER[$urandom_range(3)];
      cfg_access(1'b1, {30'b0, pick_sel});
      cfg_access(1'b0, '0);
      calm_tx = (ph % 5 == 3);

      if (ph == 1) begin
        // fill the table past full, then query it whole
        send_beat(OP_CLEAR, $urandom, $urandom);
        repeat (TABLE_DEPTH + 2) begin
          s = TIME_W'($urandom_range(1000));
          e = s + TIME_W'($urandom_range(1000));
          send_beat(OP_LOAD, s, e);
        end
        send_beat(OP_QUERY, '0, T_MAX);
        repeat (3) begin
          draw_span('0, s, e);
          send_beat(OP_QUERY, s, e);
        end
      end else begin
        r = $urandom_range(99);
        base = (r < 70) ? TIME_W'($urandom) : (r < 85) ? '0 : 32'hFFFF_FF80;
        if ($urandom_range(9) != 0) send_beat(OP_CLEAR, $urandom, $urandom);
        repeat (($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(48, 13)) begin
          draw_span(base, s, e);
          send_beat(OP_LOAD, s, e);
          maybe_noise(base);
        end
        repeat ($urandom_range(6, 1)) begin
          draw_span(base, s, e);
          send_beat(OP_QUERY, s, e);
          maybe_noise(base);
        end
      end
      ph++;
    end

    settle();
    if (mismatches == 0 && awaiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/iom_pkg.sv
src/iom_cell.sv
src/interval_overlap_match_top.sv
tb/iom_checker.sv
tb/testbench.sv
